/* design/act_dtl_pkg.sv */
// Shared constants, types and the helper function of the actuator dead time and lag core.
`timescale 1ns / 1ps

package act_dtl_pkg;

    // Depth of the dead-time ring store.
    localparam int DELAY_DEPTH = 1024;
    // Pointer width for the ring store; at least one bit.
    localparam int PTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    // Width that can hold any effective length, 0 up to DELAY_DEPTH.
    localparam int FILL_W = $clog2(DELAY_DEPTH + 1);

    localparam int SAMPLE_W = 17;
    localparam int CMD_W    = 18;
    localparam int LEN_W    = 11;
    localparam int COEF_W   = 17;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 17'd65536;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_LENGTH = 2'd0,
        CFG_LAG_COEF     = 2'd1
    } cfg_index_t;

    // Read result of the ring store: hit is low for an entry never written.
    typedef struct packed {
        logic    hit;
        sample_t data;
    } delay_rd_t;

    typedef struct packed {
        sample_t lagged;
        sample_t applied;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } fifo_stat_t;

    // Clamp a signed Q1.16 command to 0..1.0 and force zero when gated off.
    function automatic sample_t clamp_gate(input logic signed [CMD_W-1:0] cmd,
                                           input logic off);
        sample_t result;
        if (off || cmd[CMD_W-1]) begin
            result = '0;
        end else if (cmd[CMD_W-2:0] > FULL_SCALE) begin
            result = FULL_SCALE;
        end else begin
            result = cmd[CMD_W-2:0];
        end
        return result;
    endfunction

endpackage

/* design/act_dtl_delay_line.sv */
// Ring delay store with pointer, fill count and registered read port.
`timescale 1ns / 1ps

module act_dtl_delay_line (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          step,
    input  logic [act_dtl_pkg::LEN_W-1:0] length,
    input  act_dtl_pkg::sample_t          applied,
    output act_dtl_pkg::delay_rd_t        rd
);
    import act_dtl_pkg::*;

    sample_t             mem [DELAY_DEPTH];
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   len_eff, ptr_ext, idx_w, idx_inc;
    logic [PTR_W-1:0]    idx;
    logic                use_line, hit;
    sample_t             rdata_reg;
    logic                hit_reg;

    always_comb begin
        if (int'(length) > DELAY_DEPTH) begin
            len_eff = FILL_W'(DELAY_DEPTH);
        end else begin
            len_eff = FILL_W'(length);
        end
        use_line = step && (len_eff != '0);
        ptr_ext  = FILL_W'(ptr_reg);
        idx_w    = (ptr_ext >= len_eff) ? '0 : ptr_ext;
        idx      = idx_w[PTR_W-1:0];
        idx_inc  = idx_w + FILL_W'(1);
        // Entries are written from zero upwards, so written ones form a prefix.
        hit      = idx_w < fill_reg;
        ptr_next = ptr_reg;
        fill_next = fill_reg;
        if (accept && use_line) begin
            ptr_next = (idx_inc >= len_eff) ? '0 : idx_inc[PTR_W-1:0];
            if (!hit) begin
                fill_next = idx_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    // Read before write: the oldest sample leaves as the new one goes in.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= mem[idx];
            hit_reg   <= hit;
            if (use_line) begin
                mem[idx] <= applied;
            end
        end
    end

    assign rd.hit  = hit_reg;
    assign rd.data = rdata_reg;

endmodule

/* design/act_dtl_lag.sv */
// First-order lag state and its single-multiplier update.
`timescale 1ns / 1ps

module act_dtl_lag (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           step,
    input  logic                           restart,
    input  logic                           bypass,
    input  act_dtl_pkg::sample_t           applied,
    input  act_dtl_pkg::delay_rd_t         rd,
    input  logic [act_dtl_pkg::COEF_W-1:0] lag_coef,
    output act_dtl_pkg::sample_t           lag_out
);
    import act_dtl_pkg::*;

    sample_t              lag_reg, lag_next;
    sample_t              delayed, lag_base, k, clamped;
    logic signed [17:0]   diff;
    logic signed [35:0]   prod, rnd;
    logic signed [19:0]   corr;
    logic signed [20:0]   sum;

    // k*y + (1-k)*x is rewritten as x + k*(y - x), which needs one multiply.
    always_comb begin
        delayed  = bypass ? applied : (rd.hit ? rd.data : '0);
        k        = (lag_coef > FULL_SCALE) ? FULL_SCALE : lag_coef;
        lag_base = restart ? '0 : lag_reg;
        diff     = $signed({1'b0, lag_base}) - $signed({1'b0, delayed});
        prod     = $signed({1'b0, k}) * diff;
        rnd      = prod + 36'sd32768;
        corr     = rnd[35:16];
        sum      = $signed({4'b0000, delayed}) + $signed({corr[19], corr});
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > $signed({4'b0000, FULL_SCALE})) begin
            clamped = FULL_SCALE;
        end else begin
            clamped = sum[SAMPLE_W-1:0];
        end
        lag_next = step ? clamped : lag_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg <= '0;
        end else if (advance) begin
            lag_reg <= lag_next;
        end
    end

    assign lag_out = lag_next;

endmodule

/* design/act_dtl_out_fifo.sv */
// Two-entry result queue that decouples the result channel from the pipeline.
`timescale 1ns / 1ps

module act_dtl_out_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  act_dtl_pkg::out_item_t  push_item,
    input  logic                    pop_ready,
    output act_dtl_pkg::out_item_t  head_item,
    output act_dtl_pkg::fifo_stat_t stat
);
    import act_dtl_pkg::*;

    out_item_t   entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign stat.valid = cnt_reg != 2'd0;
    assign stat.full  = cnt_reg == 2'd2;
    assign pop        = stat.valid && pop_ready;
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/actuator_dead_time_and_lag_core.sv */
// Top level of the actuator dead time and first-order lag core.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  throttle command and gating flags
//  m_        out        m_tvalid/m_tready  applied and lagged throttle
//  cfg_      in         cfg_valid/ready    register index and write data
//
//  Each input beat gives one result beat; a new beat can be taken every cycle
//  while s_tready is high. An input beat first reads and writes the delay store;
//  the lag update and queuing of its result follow as the pipeline stage moves on.
//  The lag loop (one multiply and add) and the single store port set this rate.
//  Reset clears pointers, fill count, lag state and registers; the store needs no
//  clearing pass, as entries never written read as zero through the fill count.
//  When the result queue is full and a beat waits in the pipeline, s_tready drops.

module actuator_dead_time_and_lag_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [17:0] throttle_cmd, [23:18] zero
    input  logic [act_dtl_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] landed, [1] fuel_empty, [2] new_step, [3] restart
    input  logic [act_dtl_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [16:0] applied_throttle, [33:17] thrust_demand, [39:34] zero
    output logic [act_dtl_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [act_dtl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [act_dtl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import act_dtl_pkg::*;

    logic [LEN_W-1:0]  delay_length_reg;
    logic [COEF_W-1:0] lag_coef_reg;

    logic       s_accept;
    sample_t    applied;
    logic       s1_valid_reg, s1_valid_next;
    sample_t    s1_applied_reg;
    logic       s1_step_reg, s1_restart_reg, s1_bypass_reg;
    logic       s1_adv;

    delay_rd_t  rd;
    sample_t    lag_out;
    out_item_t  push_item, head_item;
    fifo_stat_t fifo_stat;

    // Always ready; user must send register writes with no beat in flight; unchecked
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_length_reg <= '0;
            lag_coef_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DELAY_LENGTH: delay_length_reg <= cfg_data[LEN_W-1:0];
                CFG_LAG_COEF:     lag_coef_reg     <= cfg_data[COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    // The pipeline stage moves on whenever the queue has room; input is refused
    // only when that stage is occupied and cannot move.
    assign s1_adv   = s1_valid_reg && !fifo_stat.full;
    assign s_tready = !(s1_valid_reg && fifo_stat.full);
    assign s_accept = s_tvalid && s_tready;

    assign applied = clamp_gate($signed(s_tdata[CMD_W-1:0]), s_tuser[0] | s_tuser[1]);

    always_comb begin
        s1_valid_next = s_accept || (s1_valid_reg && !s1_adv);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_applied_reg <= applied;
            s1_step_reg    <= s_tuser[2];
            s1_restart_reg <= s_tuser[3];
            s1_bypass_reg  <= delay_length_reg == '0;
        end
    end

    act_dtl_delay_line u_delay_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .step    (s_tuser[2]),
        .length  (delay_length_reg),
        .applied (applied),
        .rd      (rd)
    );

    act_dtl_lag u_lag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (s1_adv),
        .step     (s1_step_reg),
        .restart  (s1_restart_reg),
        .bypass   (s1_bypass_reg),
        .applied  (s1_applied_reg),
        .rd       (rd),
        .lag_coef (lag_coef_reg),
        .lag_out  (lag_out)
    );

    assign push_item.applied = s1_applied_reg;
    assign push_item.lagged  = lag_out;

    act_dtl_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_adv),
        .push_item (push_item),
        .pop_ready (m_tready),
        .head_item (head_item),
        .stat      (fifo_stat)
    );

    assign m_tvalid = fifo_stat.valid;
    assign m_tdata  = {6'b000000, head_item.lagged, head_item.applied};

    // Both result fields stay within full scale.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:17] <= FULL_SCALE) && (m_tdata[16:0] <= FULL_SCALE))
        else $error("result field above full scale");

    // An accepted beat occupies the pipeline stage on the next cycle.
    a_stage_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted beat lost before the pipeline stage");

    // A beat leaving the pipeline stage is on offer at the result port next cycle.
    a_result_offer: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_tvalid)
        else $error("advanced beat not offered on the result channel");

endmodule
